[src/radio_api_tx_frame_builder_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the transmit-request frame builder
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef RADIO_API_TX_FRAME_BUILDER_ASSERT_SVH
`define RADIO_API_TX_FRAME_BUILDER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define RTFB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame builder check failed");

// Consequent must hold in the cycle after the antecedent
`define RTFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame builder check failed");

`endif

[src/rtfb_pkg.sv]
// ----------------------------------------------------------------------------
// rtfb_pkg
// Types and constants for the transmit-request frame builder.
// ----------------------------------------------------------------------------
package rtfb_pkg;

    // Frame format
    localparam logic [7:0]  START_BYTE  = 8'h7E;
    localparam logic [7:0]  FRAME_TYPE  = 8'h10;
    localparam logic [7:0]  CHECK_BASE  = 8'hFF;
    localparam logic [15:0] HEADER_LEN  = 16'd14;
    localparam logic [7:0]  MAX_PAYLOAD = 8'd100;

    // Register reset values
    localparam logic [63:0] DEST_RESET    = 64'h0000_0000_0000_FFFF;
    localparam logic [15:0] NET_RESET     = 16'hFFFE;
    localparam logic [7:0]  IDENT_RESET   = 8'd1;
    localparam logic [7:0]  RADIUS_RESET  = 8'd0;
    localparam logic [7:0]  OPTIONS_RESET = 8'd0;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_DEST    = 3'd0,
        REG_NET     = 3'd1,
        REG_IDENT   = 3'd2,
        REG_RADIUS  = 3'd3,
        REG_OPTIONS = 3'd4
    } reg_index_t;

    // Byte positions within one emitted burst
    typedef logic [4:0] pos_t;
    localparam pos_t POS_START   = 5'd0;
    localparam pos_t POS_LEN_HI  = 5'd1;
    localparam pos_t POS_LEN_LO  = 5'd2;
    localparam pos_t POS_TYPE    = 5'd3;
    localparam pos_t POS_IDENT   = 5'd4;
    localparam pos_t POS_DEST    = 5'd5;
    localparam pos_t POS_NET_HI  = 5'd13;
    localparam pos_t POS_NET_LO  = 5'd14;
    localparam pos_t POS_RADIUS  = 5'd15;
    localparam pos_t POS_OPTIONS = 5'd16;
    localparam pos_t POS_DATA    = 5'd17;
    localparam pos_t POS_CHECK   = 5'd18;

    // Input request
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] payload_len;
        logic       first;
    } tx_req_t;

    // Output result
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last;
        logic       error;
    } tx_res_t;

endpackage

[src/radio_api_tx_frame_builder.sv]
// ----------------------------------------------------------------------------
// radio_api_tx_frame_builder
// Wraps payload bytes in a 64-bit-destination transmit-request API frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid / in_ready carry one payload request per handshake: the data
//   byte, the total payload length and a first-byte flag. out_valid /
//   out_ready carry one framed byte per handshake with last and error flags.
//   cfg_wr_en writes cfg_wdata into the register at cfg_addr
//   (destination, network address, frame id, radius, options).
// Timing:
//   A request is held in an input register and its bytes leave through an
//   output register, one byte per cycle while out_ready is high. A
//   pass-through byte moves from the input register into the output
//   register as the next request is taken, so payload bytes sustain one per
//   cycle unless stalled. For a first byte the sequencer emits 17 header
//   bytes and the data byte, plus the checksum on a one-byte frame, and
//   takes the next request with the last; a longer frame's final byte also
//   waits for its checksum. A rejected length gives a single error byte.
//   Bytes outside a frame drop without a result or waiting on the output.
// Reset clears the frame state and both stages and loads the default
// register values. When out_ready is low the output register holds its
// byte and the sequencer and input side stall behind it.
// ----------------------------------------------------------------------------
module radio_api_tx_frame_builder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_addr,
    input  logic [63:0]           cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rtfb_pkg::tx_req_t     in_req,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rtfb_pkg::tx_res_t     out_resp
);

    // Configuration registers
    logic [63:0] dest_reg;
    logic [15:0] net_reg;
    logic [7:0]  ident_reg;
    logic [7:0]  radius_reg;
    logic [7:0]  options_reg;

    // Input stage and sequencer
    logic              hold_valid_reg, hold_valid_next;
    rtfb_pkg::tx_req_t hold_req_reg, hold_req_next;
    rtfb_pkg::pos_t    pos_reg, pos_next;

    // Frame state
    logic        in_frame_reg, in_frame_next;
    logic [6:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]  sum_reg, sum_next;

    // Output stage
    logic              out_valid_reg, out_valid_next;
    rtfb_pkg::tx_res_t out_resp_reg, out_resp_next;

    logic              out_free;
    logic              hold_done;
    logic              emit;
    logic              add_sum;
    logic              bad_len;
    logic [15:0]       api_len;
    logic [2:0]        dest_sel;
    logic [7:0]        dest_byte;
    rtfb_pkg::tx_res_t res;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_reg    <= rtfb_pkg::DEST_RESET;
            net_reg     <= rtfb_pkg::NET_RESET;
            ident_reg   <= rtfb_pkg::IDENT_RESET;
            radius_reg  <= rtfb_pkg::RADIUS_RESET;
            options_reg <= rtfb_pkg::OPTIONS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                rtfb_pkg::REG_DEST:    dest_reg    <= cfg_wdata;
                rtfb_pkg::REG_NET:     net_reg     <= cfg_wdata[15:0];
                rtfb_pkg::REG_IDENT:   ident_reg   <= cfg_wdata[7:0];
                rtfb_pkg::REG_RADIUS:  radius_reg  <= cfg_wdata[7:0];
                rtfb_pkg::REG_OPTIONS: options_reg <= cfg_wdata[7:0];
                default:               ;
            endcase
        end
    end

    // Decode the held request
    assign out_free  = !out_valid_reg || out_ready;
    assign bad_len   = (hold_req_reg.payload_len == 8'd0) ||
                       (hold_req_reg.payload_len > rtfb_pkg::MAX_PAYLOAD);
    assign api_len   = rtfb_pkg::HEADER_LEN + {8'd0, hold_req_reg.payload_len};
    assign dest_sel  = 3'(pos_reg - rtfb_pkg::POS_DEST);
    assign dest_byte = dest_reg[8 * (7 - dest_sel) +: 8];

    // Sequence the bytes of the held request
    always_comb
    begin
        hold_done       = 1'b0;
        emit            = 1'b0;
        add_sum         = 1'b0;
        res             = '0;
        pos_next        = pos_reg;
        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        sum_next        = sum_reg;

        if (hold_valid_reg)
        begin
            if (!hold_req_reg.first && !in_frame_reg)
            begin
                // Drop a byte outside any frame
                hold_done = 1'b1;
            end
            else if (out_free)
            begin
                emit     = 1'b1;
                pos_next = rtfb_pkg::pos_t'(pos_reg + 5'd1);
                if (hold_req_reg.first && bad_len && pos_reg == rtfb_pkg::POS_START)
                begin
                    // Reject the frame with a single error byte
                    res.last        = 1'b1;
                    res.error       = 1'b1;
                    in_frame_next   = 1'b0;
                    bytes_left_next = 7'd0;
                    sum_next        = 8'd0;
                    hold_done       = 1'b1;
                end
                else
                begin
                    case (pos_reg)
                        rtfb_pkg::POS_START:
                        begin
                            res.frame_byte  = rtfb_pkg::START_BYTE;
                            sum_next        = 8'd0;
                            in_frame_next   = 1'b1;
                            bytes_left_next = hold_req_reg.payload_len[6:0];
                        end
                        rtfb_pkg::POS_LEN_HI:  res.frame_byte = api_len[15:8];
                        rtfb_pkg::POS_LEN_LO:  res.frame_byte = api_len[7:0];
                        rtfb_pkg::POS_TYPE:
                        begin
                            res.frame_byte = rtfb_pkg::FRAME_TYPE;
                            add_sum        = 1'b1;
                        end
                        rtfb_pkg::POS_IDENT:
                        begin
                            res.frame_byte = ident_reg;
                            add_sum        = 1'b1;
                        end
                        rtfb_pkg::POS_NET_HI:
                        begin
                            res.frame_byte = net_reg[15:8];
                            add_sum        = 1'b1;
                        end
                        rtfb_pkg::POS_NET_LO:
                        begin
                            res.frame_byte = net_reg[7:0];
                            add_sum        = 1'b1;
                        end
                        rtfb_pkg::POS_RADIUS:
                        begin
                            res.frame_byte = radius_reg;
                            add_sum        = 1'b1;
                        end
                        rtfb_pkg::POS_OPTIONS:
                        begin
                            res.frame_byte = options_reg;
                            add_sum        = 1'b1;
                        end
                        rtfb_pkg::POS_DATA:
                        begin
                            res.frame_byte  = hold_req_reg.payload_byte;
                            add_sum         = 1'b1;
                            bytes_left_next = 7'(bytes_left_reg - 7'd1);
                            // Go on to the checksum after the final byte
                            if (bytes_left_next == 7'd0)
                                pos_next = rtfb_pkg::POS_CHECK;
                            else
                                hold_done = 1'b1;
                        end
                        rtfb_pkg::POS_CHECK:
                        begin
                            res.frame_byte = rtfb_pkg::CHECK_BASE - sum_reg;
                            res.last       = 1'b1;
                            in_frame_next  = 1'b0;
                            sum_next       = 8'd0;
                            hold_done      = 1'b1;
                        end
                        default:
                        begin
                            // Destination bytes, most significant first
                            res.frame_byte = dest_byte;
                            add_sum        = 1'b1;
                        end
                    endcase
                    if (add_sum)
                        sum_next = sum_reg + res.frame_byte;
                end
            end
        end
    end

    assign in_ready = !hold_valid_reg || hold_done;

    // Load the input stage and the output stage
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_req_next   = hold_req_reg;
        out_valid_next  = out_valid_reg;
        out_resp_next   = out_resp_reg;

        if (hold_done)
            hold_valid_next = 1'b0;
        if (in_valid && in_ready)
        begin
            hold_valid_next = 1'b1;
            hold_req_next   = in_req;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_resp_next  = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Pick the starting position of a newly accepted request
    rtfb_pkg::pos_t pos_load;
    assign pos_load = in_req.first ? rtfb_pkg::POS_START : rtfb_pkg::POS_DATA;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            pos_reg        <= rtfb_pkg::POS_START;
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 7'd0;
            sum_reg        <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            pos_reg        <= (in_valid && in_ready) ? pos_load : pos_next;
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
            sum_reg        <= sum_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hold_req_reg <= hold_req_next;
        out_resp_reg <= out_resp_next;
    end

    assign out_valid = out_valid_reg;
    assign out_resp  = out_resp_reg;

    // Checks
    `include "radio_api_tx_frame_builder_assert.svh"

    `RTFB_ASSERT_SAME(a_error_is_last, out_valid && out_resp.error, out_resp.last)
    `RTFB_ASSERT_SAME(a_error_byte_zero, out_valid && out_resp.error, out_resp.frame_byte == 8'd0)
    `RTFB_ASSERT_SAME(a_pos_in_range, hold_valid_reg, pos_reg <= rtfb_pkg::POS_CHECK)
    `RTFB_ASSERT_NEXT(a_accept_holds, in_valid && in_ready, hold_valid_reg)

endmodule

[dv/radio_api_tx_frame_builder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_api_tx_frame_builder_tb
// Self-checking bench for the transmit-request frame builder. A short list
// of hand-picked requests covers the length limits, rejected and stray
// bytes, one-byte frames and frames abandoned by a new first byte. Random
// frames follow under four register settings. Every accepted request runs
// through a local frame model, and each output byte is checked against the
// oldest byte it predicts. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module radio_api_tx_frame_builder_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;

    // How the expected bytes of a listed request are obtained
    typedef enum logic [1:0] {
        BY_MODEL  = 2'd0,
        NO_RESULT = 2'd1,
        REJECT    = 2'd2
    } check_kind_t;

    typedef struct {
        rtfb_pkg::tx_req_t req;
        check_kind_t       kind;
    } plan_row_t;

    localparam rtfb_pkg::tx_res_t REJECT_RES = {8'h00, 1'b1, 1'b1};

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [2:0]        cfg_addr;
    logic [63:0]       cfg_wdata;
    logic              in_valid;
    logic              in_ready;
    rtfb_pkg::tx_req_t in_req;
    logic              out_valid;
    logic              out_ready;
    rtfb_pkg::tx_res_t out_resp;

    // Register copies and frame state of the local model
    logic [63:0] dest_shadow;
    logic [15:0] net_shadow;
    logic [7:0]  ident_shadow;
    logic [7:0]  radius_shadow;
    logic [7:0]  options_shadow;
    logic [6:0]  bytes_open;
    logic [7:0]  frame_sum;
    logic        frame_open;
    logic        discarding;

    rtfb_pkg::tx_res_t burst_q[$];
    rtfb_pkg::tx_res_t frame_bytes_due[$];
    plan_row_t         plan[$];

    int          sent_items;
    int          live_items;
    int          frames_started;
    int          frames_rejected;
    int          bytes_checked;
    int          fail_count;
    int          cycle_count;
    bit          no_idle;

    radio_api_tx_frame_builder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_resp  (out_resp)
    );

    always #6 clk = ~clk;

    // Append one predicted byte, adding it to the checksum where it counts
    function automatic void add_byte(logic [7:0] b, logic last_f, logic err_f, bit summed);
        rtfb_pkg::tx_res_t r;
        if (summed)
            frame_sum = frame_sum + b;
        r.frame_byte = b;
        r.last = last_f;
        r.error = err_f;
        burst_q.push_back(r);
    endfunction

    // Work out every byte one request emits and advance the frame state
    function automatic void predict_frame_bytes(rtfb_pkg::tx_req_t r);
        logic [15:0] api_len;
        int i;
        burst_q.delete();
        if (r.first) begin
            if (r.payload_len == 8'd0 || r.payload_len > rtfb_pkg::MAX_PAYLOAD) begin
                frame_open = 1'b0;
                discarding = 1'b1;
                bytes_open = '0;
                frame_sum = '0;
                add_byte(8'h00, 1'b1, 1'b1, 1'b0);
                return;
            end
            discarding = 1'b0;
            frame_open = 1'b1;
            frame_sum = '0;
            api_len = rtfb_pkg::HEADER_LEN + {8'h00, r.payload_len};
            add_byte(rtfb_pkg::START_BYTE, 1'b0, 1'b0, 1'b0);
            add_byte(api_len[15:8], 1'b0, 1'b0, 1'b0);
            add_byte(api_len[7:0], 1'b0, 1'b0, 1'b0);
            add_byte(rtfb_pkg::FRAME_TYPE, 1'b0, 1'b0, 1'b1);
            add_byte(ident_shadow, 1'b0, 1'b0, 1'b1);
            for (i = 7; i >= 0; i--)
                add_byte(dest_shadow[8*i +: 8], 1'b0, 1'b0, 1'b1);
            add_byte(net_shadow[15:8], 1'b0, 1'b0, 1'b1);
            add_byte(net_shadow[7:0], 1'b0, 1'b0, 1'b1);
            add_byte(radius_shadow, 1'b0, 1'b0, 1'b1);
            add_byte(options_shadow, 1'b0, 1'b0, 1'b1);
            bytes_open = r.payload_len[6:0];
        end else if (!frame_open) begin
            return;
        end
        add_byte(r.payload_byte, 1'b0, 1'b0, 1'b1);
        bytes_open = bytes_open - 7'd1;
        if (bytes_open == 7'd0) begin
            add_byte(rtfb_pkg::CHECK_BASE - frame_sum, 1'b1, 1'b0, 1'b0);
            frame_open = 1'b0;
            frame_sum = '0;
        end
    endfunction

    function automatic plan_row_t row(logic [7:0] b, logic [7:0] n, logic f,
                                      check_kind_t k);
        plan_row_t p;
        p.req.payload_byte = b;
        p.req.payload_len = n;
        p.req.first = f;
        p.kind = k;
        return p;
    endfunction

    // Hand one request over, then queue the bytes it should produce
    task automatic send_request(rtfb_pkg::tx_req_t r, check_kind_t kind);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_items++;
        predict_frame_bytes(r);
        if (burst_q.size() > 0)
            live_items++;
        if (r.first && burst_q.size() > 1)
            frames_started++;
        if (r.first && burst_q.size() == 1)
            frames_rejected++;
        case (kind)
            NO_RESULT: ;
            REJECT:    frame_bytes_due.push_back(REJECT_RES);
            default:   foreach (burst_q[j]) frame_bytes_due.push_back(burst_q[j]);
        endcase
    endtask

    // Write all five registers back to back; the block is idle here
    task automatic load_config(logic [63:0] d, logic [63:0] n, logic [63:0] id,
                               logic [63:0] rad, logic [63:0] opt);
        rtfb_pkg::reg_index_t idx;
        logic [63:0] v;
        for (int k = 0; k < 5; k++) begin
            idx = rtfb_pkg::reg_index_t'(k);
            case (idx)
                rtfb_pkg::REG_DEST:   begin v = d;   dest_shadow = d;           end
                rtfb_pkg::REG_NET:    begin v = n;   net_shadow = n[15:0];      end
                rtfb_pkg::REG_IDENT:  begin v = id;  ident_shadow = id[7:0];    end
                rtfb_pkg::REG_RADIUS: begin v = rad; radius_shadow = rad[7:0];  end
                default:              begin v = opt; options_shadow = opt[7:0]; end
            endcase
            cfg_wr_en <= 1'b1;
            cfg_addr <= idx;
            cfg_wdata <= v;
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Hold until every predicted byte is out, then let dropped requests clear
    task automatic drain();
        in_valid <= 1'b0;
        while (frame_bytes_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random frames, mostly well formed, with noise, rejects and cut frames
    task automatic run_random(int want);
        int goal;
        int pick;
        int len;
        int stop_at;
        rtfb_pkg::tx_req_t r;
        goal = sent_items + want;
        while (sent_items < goal) begin
            no_idle = ($urandom_range(0, 99) < 15);
            pick = $urandom_range(0, 99);
            r.payload_byte = 8'($urandom_range(0, 255));
            if (pick < 6) begin
                r.payload_len = 8'($urandom_range(0, 255));
                r.first = 1'b0;
                send_request(r, BY_MODEL);
            end else if (pick < 14) begin
                r.payload_len = ($urandom_range(0, 3) == 0) ? 8'd0
                                                            : 8'($urandom_range(101, 255));
                r.first = 1'b1;
                send_request(r, BY_MODEL);
                repeat ($urandom_range(0, 2)) begin
                    r.payload_byte = 8'($urandom_range(0, 255));
                    r.payload_len = 8'($urandom_range(0, 255));
                    r.first = 1'b0;
                    send_request(r, BY_MODEL);
                end
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    len = $urandom_range(90, 100);
                else if (pick < 15)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(1, 8);
                stop_at = len - 1;
                if (len >= 2 && $urandom_range(0, 99) < 8)
                    stop_at = $urandom_range(0, len - 2);
                r.payload_len = 8'(len);
                r.first = 1'b1;
                send_request(r, BY_MODEL);
                for (int k = 0; k < stop_at && sent_items < goal; k++) begin
                    r.payload_byte = 8'($urandom_range(0, 255));
                    r.payload_len = 8'($urandom_range(0, 255));
                    r.first = 1'b0;
                    send_request(r, BY_MODEL);
                end
            end
        end
    endtask

    // Cycle watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Check each output byte against the oldest prediction
    always @(posedge clk) begin
        rtfb_pkg::tx_res_t want;
        if (rst_n && out_valid && out_ready) begin
            if (frame_bytes_due.size() == 0) begin
                $error("unexpected output byte %02h (last %0b, error %0b)",
                       out_resp.frame_byte, out_resp.last, out_resp.error);
                fail_count++;
            end else begin
                want = frame_bytes_due.pop_front();
                bytes_checked++;
                if (out_resp.frame_byte !== want.frame_byte) begin
                    $error("frame_byte expected %02h actual %02h",
                           want.frame_byte, out_resp.frame_byte);
                    fail_count++;
                end
                if (out_resp.last !== want.last) begin
                    $error("last expected %0b actual %0b", want.last, out_resp.last);
                    fail_count++;
                end
                if (out_resp.error !== want.error) begin
                    $error("error expected %0b actual %0b", want.error, out_resp.error);
                    fail_count++;
                end
            end
        end
    end

    // Output side: hold out_ready low for a random stall before each byte
    initial begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Stimulus
    initial begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr <= rtfb_pkg::REG_DEST;
        cfg_wdata <= '0;
        in_valid <= 1'b0;
        in_req <= '0;
        no_idle = 1'b0;
        sent_items = 0;
        live_items = 0;
        frames_started = 0;
        frames_rejected = 0;
        bytes_checked = 0;
        fail_count = 0;
        cycle_count = 0;
        dest_shadow = rtfb_pkg::DEST_RESET;
        net_shadow = rtfb_pkg::NET_RESET;
        ident_shadow = rtfb_pkg::IDENT_RESET;
        radius_shadow = rtfb_pkg::RADIUS_RESET;
        options_shadow = rtfb_pkg::OPTIONS_RESET;
        bytes_open = '0;
        frame_sum = '0;
        frame_open = 1'b0;
        discarding = 1'b0;

        // Directed requests under the reset register values
        plan.push_back(row(8'h5A, 8'd3,   1'b0, NO_RESULT)); // stray after reset
        plan.push_back(row(8'h00, 8'd0,   1'b1, REJECT));    // zero length
        plan.push_back(row(8'hFF, 8'd255, 1'b0, NO_RESULT)); // dropped
        plan.push_back(row(8'h11, 8'd101, 1'b1, REJECT));    // one over the limit
        plan.push_back(row(8'h22, 8'd255, 1'b1, REJECT));
        plan.push_back(row(8'h33, 8'd128, 1'b1, REJECT));
        plan.push_back(row(8'h00, 8'd1,   1'b1, BY_MODEL));  // single byte frames
        plan.push_back(row(8'hFF, 8'd1,   1'b1, BY_MODEL));
        plan.push_back(row(8'hA5, 8'd3,   1'b1, BY_MODEL));
        plan.push_back(row(8'h5A, 8'd0,   1'b0, BY_MODEL));
        plan.push_back(row(8'hFF, 8'd255, 1'b0, BY_MODEL));
        plan.push_back(row(8'h01, 8'd0,   1'b0, NO_RESULT)); // stray after close
        plan.push_back(row(8'h12, 8'd100, 1'b1, BY_MODEL));  // longest frame, left open
        plan.push_back(row(8'h34, 8'd0,   1'b0, BY_MODEL));
        plan.push_back(row(8'h56, 8'd2,   1'b1, BY_MODEL));  // abandons the open frame
        plan.push_back(row(8'h78, 8'h7F,  1'b0, BY_MODEL));
        plan.push_back(row(8'h9A, 8'd5,   1'b1, BY_MODEL));
        plan.push_back(row(8'hBC, 8'd0,   1'b0, BY_MODEL));
        plan.push_back(row(8'hDE, 8'd0,   1'b1, REJECT));    // reject closes open frame
        plan.push_back(row(8'hEF, 8'd5,   1'b0, NO_RESULT));
        plan.push_back(row(8'h80, 8'd1,   1'b1, BY_MODEL));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_request(plan[i].req, plan[i].kind);
        run_random(37);
        drain();

        // All ones
        load_config('1, '1, '1, '1, '1);
        run_random(37);
        drain();

        // All zeros
        load_config('0, '0, '0, '0, '0);
        run_random(37);
        drain();

        // Random values, upper write bits included
        load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        run_random(38);
        drain();

        if (frame_bytes_due.size() != 0) begin
            $error("%0d predicted bytes never arrived", frame_bytes_due.size());
            fail_count++;
        end

        $display("Run sent %0d requests, %0d with output: %0d frames built, %0d rejected.",
                 sent_items, live_items, frames_started, frames_rejected);
        $display("Checked %0d output bytes over four register settings.", bytes_checked);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
